### hdl/fbdp_pkg.sv
// Shared types, register codes and constants for the fragment blend, dither and pack pipeline.
`timescale 1ns / 1ps
`default_nettype none
package fbdp_pkg;

   localparam int CHAN_W  = 8;
   localparam int FRONT_W = 9;
   localparam int MIX_W   = 10;
   localparam int FIELD_W = 5;
   localparam int OFF_W   = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_TEXTURED           = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RAW_TEXTURE        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TRANSLUCENT_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIX_MODE           = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KEEP_MASKED        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DITHER_ENABLE      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_FORCE_MASK         = 3'd6;

   localparam logic [1:0] BLEND_HALF     = 2'd0;
   localparam logic [1:0] BLEND_ADD      = 2'd1;
   localparam logic [1:0] BLEND_SUBTRACT = 2'd2;
   localparam logic [1:0] BLEND_QUARTER  = 2'd3;

   localparam int MASK_POS = 15;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   localparam logic signed [OFF_W-1:0] DITHER_TABLE [0:3][0:3] = '{
      '{-4'sd4,  4'sd0, -4'sd3,  4'sd1},
      '{ 4'sd2, -4'sd2,  4'sd3, -4'sd1},
      '{-4'sd3,  4'sd1, -4'sd4,  4'sd0},
      '{ 4'sd3, -4'sd1,  4'sd2, -4'sd2}
   };

   typedef struct packed {
      logic       textured;
      logic       raw_texture;
      logic       translucent_enable;
      logic [1:0] mix_mode;
      logic       keep_masked;
      logic       dither_enable;
      logic       force_mask;
   } cfg_type;

   typedef struct packed {
      logic [9:0]        pos_x;
      logic [8:0]        pos_y;
      logic [CHAN_W-1:0] tint_red;
      logic [CHAN_W-1:0] tint_green;
      logic [CHAN_W-1:0] tint_blue;
      logic [15:0]       texel_word;
      logic [15:0]       behind_pixel;
   } frag_type;

   typedef struct packed {
      logic                         write;
      logic                         blend;
      logic [9:0]                   pos_x;
      logic [8:0]                   pos_y;
      logic [2:0][FRONT_W-1:0]      front;
      logic [3*FIELD_W-1:0]         back;
      logic signed [OFF_W-1:0]      offset;
   } front_type;

   typedef struct packed {
      logic                         write;
      logic [9:0]                   pos_x;
      logic [8:0]                   pos_y;
      logic [2:0][MIX_W-1:0]        color;
      logic signed [OFF_W-1:0]      offset;
   } mix_type;

   typedef struct packed {
      logic        write_enable;
      logic [9:0]  out_x;
      logic [8:0]  out_y;
      logic [15:0] pixel_out;
   } result_type;

endpackage
`default_nettype wire

### hdl/fbdp_front.sv
// First stage: texel expansion, tint modulation, write and blend decisions, dither offset.
`timescale 1ns / 1ps
`default_nettype none
module fbdp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fbdp_pkg::cfg_type    cfg,
   input  wire logic                 frag_valid,
   input  wire fbdp_pkg::frag_type   frag,
   output logic                      front_valid,
   output fbdp_pkg::front_type       front
);

   logic                      valid_ff;
   fbdp_pkg::front_type       data_ff;
   fbdp_pkg::front_type       data_in;
   logic [2:0][fbdp_pkg::CHAN_W-1:0] tint;
   logic [2:0][fbdp_pkg::CHAN_W-1:0] texel8;
   logic [2:0][15:0]                 product;

   always_comb begin
      tint[0] = frag.tint_red;
      tint[1] = frag.tint_green;
      tint[2] = frag.tint_blue;
      data_in.pos_x  = frag.pos_x;
      data_in.pos_y  = frag.pos_y;
      data_in.back   = frag.behind_pixel[3*fbdp_pkg::FIELD_W-1:0];
      data_in.offset = cfg.dither_enable
                     ? fbdp_pkg::DITHER_TABLE[frag.pos_y[1:0]][frag.pos_x[1:0]]
                     : '0;
      for (int i = 0; i < 3; i++) begin
         texel8[i]  = {frag.texel_word[i*fbdp_pkg::FIELD_W +: fbdp_pkg::FIELD_W], 3'b000};
         product[i] = {8'h00, texel8[i]} * {8'h00, tint[i]};
         if (!cfg.textured) begin
            data_in.front[i] = {1'b0, tint[i]};
         end else if (cfg.raw_texture) begin
            data_in.front[i] = {1'b0, texel8[i]};
         end else begin
            data_in.front[i] = product[i][15:7];
         end
      end
      data_in.write = !(cfg.textured && (frag.texel_word == 16'h0000))
                    && !(cfg.keep_masked && frag.behind_pixel[fbdp_pkg::MASK_POS]);
      data_in.blend = cfg.translucent_enable
                    && (!cfg.textured || frag.texel_word[fbdp_pkg::MASK_POS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= frag_valid;
      end
      data_ff <= data_in;
   end

   assign front_valid = valid_ff;
   assign front       = data_ff;

endmodule
`default_nettype wire

### hdl/fbdp_blend.sv
// Second stage: optional per-channel blend of front color and expanded behind pixel.
`timescale 1ns / 1ps
`default_nettype none
module fbdp_blend (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fbdp_pkg::cfg_type    cfg,
   input  wire logic                 front_valid,
   input  wire fbdp_pkg::front_type  front,
   output logic                      mix_valid,
   output fbdp_pkg::mix_type         mix
);

   logic                  valid_ff;
   fbdp_pkg::mix_type     data_ff;
   fbdp_pkg::mix_type     data_in;
   logic [2:0][fbdp_pkg::MIX_W-1:0] b;
   logic [2:0][fbdp_pkg::MIX_W-1:0] f;

   always_comb begin
      data_in.write  = front.write;
      data_in.pos_x  = front.pos_x;
      data_in.pos_y  = front.pos_y;
      data_in.offset = front.offset;
      for (int i = 0; i < 3; i++) begin
         b[i] = {2'b00, front.back[i*fbdp_pkg::FIELD_W +: fbdp_pkg::FIELD_W], 3'b000};
         f[i] = {1'b0, front.front[i]};
         if (!front.blend) begin
            data_in.color[i] = f[i];
         end else begin
            case (cfg.mix_mode)
               fbdp_pkg::BLEND_HALF:     data_in.color[i] = (b[i] >> 1) + (f[i] >> 1);
               fbdp_pkg::BLEND_ADD:      data_in.color[i] = b[i] + f[i];
               fbdp_pkg::BLEND_SUBTRACT: data_in.color[i] = (f[i] < b[i]) ? b[i] - f[i] : '0;
               default:                  data_in.color[i] = b[i] + (f[i] >> 2);
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= front_valid;
      end
      data_ff <= data_in;
   end

   assign mix_valid = valid_ff;
   assign mix       = data_ff;

endmodule
`default_nettype wire

### hdl/fbdp_pack.sv
// Third stage: dither add, clamp, truncate to 5:5:5 and pack with the mask bit.
`timescale 1ns / 1ps
`default_nettype none
module fbdp_pack (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fbdp_pkg::cfg_type    cfg,
   input  wire logic                 mix_valid,
   input  wire fbdp_pkg::mix_type    mix,
   output logic                      result_valid,
   output fbdp_pkg::result_type      result
);

   logic                   valid_ff;
   fbdp_pkg::result_type   data_ff;
   fbdp_pkg::result_type   data_in;
   logic signed [fbdp_pkg::MIX_W+1:0]  sum [3];
   logic [fbdp_pkg::CHAN_W-1:0]        clamped [3];
   logic [3*fbdp_pkg::FIELD_W-1:0]     rgb;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = $signed({2'b00, mix.color[i]})
                + $signed({{(fbdp_pkg::MIX_W+2-fbdp_pkg::OFF_W){mix.offset[fbdp_pkg::OFF_W-1]}},
                           mix.offset});
         if (sum[i] < 0) begin
            clamped[i] = '0;
         end else if (sum[i] > $signed({4'b0000, fbdp_pkg::CHAN_MAX})) begin
            clamped[i] = fbdp_pkg::CHAN_MAX;
         end else begin
            clamped[i] = sum[i][fbdp_pkg::CHAN_W-1:0];
         end
         rgb[i*fbdp_pkg::FIELD_W +: fbdp_pkg::FIELD_W] = clamped[i][7:3];
      end
      data_in.write_enable = mix.write;
      data_in.out_x        = mix.pos_x;
      data_in.out_y        = mix.pos_y;
      data_in.pixel_out    = mix.write ? {cfg.force_mask, rgb} : 16'h0000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= mix_valid;
      end
      data_ff <= data_in;
   end

   assign result_valid = valid_ff;
   assign result       = data_ff;

endmodule
`default_nettype wire

### hdl/fragment_blend_dither_pack_top.sv
// Top level: configuration registers and the three-stage fragment pipeline.
`timescale 1ns / 1ps
`default_nettype none
// One fragment is taken in every clock cycle and its result appears on the rsp_ ports
// after the three register stages (tint multiply, blend, dither and pack), marked by
// rsp_valid for one cycle. busy stays low, so start alone commits a transfer. The
// receiver cannot stall and must take every result in the cycle it is shown. Write
// registers through csr_ only while no fragment is in flight.
module fragment_blend_dither_pack_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [9:0]  req_pos_x,
   input  wire logic [8:0]  req_pos_y,
   input  wire logic [7:0]  req_tint_red,
   input  wire logic [7:0]  req_tint_green,
   input  wire logic [7:0]  req_tint_blue,
   input  wire logic [15:0] req_texel_word,
   input  wire logic [15:0] req_behind_pixel,
   output logic             rsp_valid,
   output logic             rsp_write_enable,
   output logic [9:0]       rsp_out_x,
   output logic [8:0]       rsp_out_y,
   output logic [15:0]      rsp_pixel_out,
   input  wire logic        csr_write_enable,
   input  wire logic [fbdp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fbdp_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   fbdp_pkg::cfg_type    cfg_ff;
   fbdp_pkg::cfg_type    cfg_in;
   fbdp_pkg::frag_type   frag;
   fbdp_pkg::front_type  front;
   fbdp_pkg::mix_type    mix;
   fbdp_pkg::result_type result;
   logic                 frag_valid;
   logic                 front_valid;
   logic                 mix_valid;

   assign busy       = 1'b0;
   assign frag_valid = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            fbdp_pkg::REG_TEXTURED:           cfg_in.textured           = csr_write_data[0];
            fbdp_pkg::REG_RAW_TEXTURE:        cfg_in.raw_texture        = csr_write_data[0];
            fbdp_pkg::REG_TRANSLUCENT_ENABLE: cfg_in.translucent_enable = csr_write_data[0];
            fbdp_pkg::REG_MIX_MODE:           cfg_in.mix_mode           = csr_write_data;
            fbdp_pkg::REG_KEEP_MASKED:        cfg_in.keep_masked        = csr_write_data[0];
            fbdp_pkg::REG_DITHER_ENABLE:      cfg_in.dither_enable      = csr_write_data[0];
            fbdp_pkg::REG_FORCE_MASK:         cfg_in.force_mask         = csr_write_data[0];
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      frag.pos_x        = req_pos_x;
      frag.pos_y        = req_pos_y;
      frag.tint_red     = req_tint_red;
      frag.tint_green   = req_tint_green;
      frag.tint_blue    = req_tint_blue;
      frag.texel_word   = req_texel_word;
      frag.behind_pixel = req_behind_pixel;
   end

   fbdp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .frag_valid  (frag_valid),
      .frag        (frag),
      .front_valid (front_valid),
      .front       (front)
   );

   fbdp_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .front_valid (front_valid),
      .front       (front),
      .mix_valid   (mix_valid),
      .mix         (mix)
   );

   fbdp_pack u_pack (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .mix_valid    (mix_valid),
      .mix          (mix),
      .result_valid (rsp_valid),
      .result       (result)
   );

   assign rsp_write_enable = result.write_enable;
   assign rsp_out_x        = result.out_x;
   assign rsp_out_y        = result.out_y;
   assign rsp_pixel_out    = result.pixel_out;

endmodule
`default_nettype wire
